// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define CRG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crg assertion failed");

// Next-cycle implication, quiet while reset is high.
`define CRG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crg assertion failed");

// Property that holds at every edge.
`define CRG_ASSERT_ALW(lbl, expr) \
  lbl: assert property (@(posedge clk) (expr)) else $error("crg assertion failed");

`endif

// ===== rtl/core/crg_pkg.sv =====
package crg_pkg;

  // One stored request: owning client and its request identifier.
  typedef struct packed {
    logic [7:0]  client;
    logic [31:0] request;
  } entry_t;

  // Command word broadcast to every cell of one list.
  typedef struct packed {
    logic append;
    logic pop;
    logic mark_one;
    logic mark_all;
    logic remove;
  } list_cmd_t;

  localparam int NUM_REGS    = 4;
  localparam int CAP_W       = 4;
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = 6;

  localparam logic [1:0] OP_ACQUIRE        = 2'd0;
  localparam logic [1:0] OP_RELEASE_ONE    = 2'd1;
  localparam logic [1:0] OP_RELEASE_CLIENT = 2'd2;
  localparam logic [1:0] OP_SHUTDOWN       = 2'd3;

endpackage

// ===== rtl/core/crg_cell.sv =====
module crg_cell (
  input  logic               clk,
  input  logic               rst,
  input  crg_pkg::list_cmd_t cmd,
  input  logic               valid,
  input  logic               load,
  input  logic [7:0]         key_client,
  input  logic [31:0]        key_request,
  input  crg_pkg::entry_t    din,
  input  crg_pkg::entry_t    nb_entry,
  input  logic               nb_mark,
  input  logic               hit_in,
  input  logic               seen_in,
  output crg_pkg::entry_t    entry,
  output logic               mark,
  output logic               hit_out,
  output logic               seen_out
);

  logic match;
  logic shift;

  // A cell matches on client, and on request too unless all of a client goes.
  assign match = valid && (entry.client == key_client) &&
                 (cmd.mark_all || (entry.request == key_request));
  assign hit_out  = hit_in | match;
  assign seen_out = seen_in | mark;

  // On a pop every cell takes its upper neighbor; on a remove, cells at and above the lowest marked one do.
  assign shift = cmd.pop | (cmd.remove & (seen_in | mark));

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= nb_entry;
    end else if (load) begin
      entry <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (shift) begin
      mark <= nb_mark;
    end else if (cmd.mark_one) begin
      mark <= match & ~hit_in;
    end else if (cmd.mark_all) begin
      mark <= match;
    end
  end

endmodule

// ===== rtl/core/crg_list.sv =====
module crg_list #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  crg_pkg::list_cmd_t         cmd,
  input  logic [7:0]                 key_client,
  input  logic [31:0]                key_request,
  input  crg_pkg::entry_t            din,
  output crg_pkg::entry_t            head,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       any_mark,
  output logic                       hit
);

  localparam int CNTW = $clog2(DEPTH + 1);

  crg_pkg::entry_t ent [DEPTH];
  logic            mk  [DEPTH];
  logic            hit_c  [DEPTH+1];
  logic            seen_c [DEPTH+1];

  assign hit_c[0]  = 1'b0;
  assign seen_c[0] = 1'b0;

  // Row of cells; each hands its entry and mark down to the one below.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    crg_pkg::entry_t nb_e;
    logic            nb_m;
    if (i < DEPTH - 1) begin : g_mid
      assign nb_e = ent[i+1];
      assign nb_m = mk[i+1];
    end else begin : g_end
      assign nb_e = '0;
      assign nb_m = 1'b0;
    end
    crg_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .valid      (CNTW'(i) < count),
      .load       (cmd.append && (count == CNTW'(i))),
      .key_client (key_client),
      .key_request(key_request),
      .din        (din),
      .nb_entry   (nb_e),
      .nb_mark    (nb_m),
      .hit_in     (hit_c[i]),
      .seen_in    (seen_c[i]),
      .entry      (ent[i]),
      .mark       (mk[i]),
      .hit_out    (hit_c[i+1]),
      .seen_out   (seen_c[i+1])
    );
  end

  assign head     = ent[0];
  assign any_mark = seen_c[DEPTH];
  assign hit      = hit_c[DEPTH];

  // Fill count of the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append) begin
      count <= count + CNTW'(1);
    end else if (cmd.pop && (count != '0)) begin
      count <= count - CNTW'(1);
    end else if (cmd.remove && any_mark) begin
      count <= count - CNTW'(1);
    end
  end

endmodule

// ===== rtl/core/counted_resource_grant_with_wait_queue_top.sv =====
// Channel   Handshake                       Payload
// item in   start, busy                     operation, client_tag, request_tag,
//                                           resource_kind, will_wait
// result    strobe (one cycle, no stall)    reply_client, reply_request,
//                                           granted, last
// config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// An acquire's result passes the pending register, then the strobe register; the block
// stays busy through the finish state. A release visits each addressed kind: check, mark
// (and waiter mark for a single release), removal of marked entries (both rows in parallel),
// waiter grants and the next state; a zero-capacity kind skips to next. Finish ends it.
// Reset is synchronous and clears counts, marks, capacities and shutdown.
// Results cannot be stalled; each result is shown for one cycle only.
module counted_resource_grant_with_wait_queue_top #(
  parameter int NUM_KINDS   = 4,
  parameter int MAX_HOLDERS = 8,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  client_tag,
  input  logic [31:0] request_tag,
  input  logic [1:0]  resource_kind,
  input  logic        will_wait,
  output logic        strobe,
  output logic [7:0]  reply_client,
  output logic [31:0] reply_request,
  output logic        granted,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW  = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int IW  = (KW > 2) ? KW : 2;
  localparam int HCW = $clog2(MAX_HOLDERS + 1);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int CW  = (HCW > 4) ? HCW : 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MARK   = 3'd2;
  localparam logic [2:0] S_MARKW  = 3'd3;
  localparam logic [2:0] S_REMOVE = 3'd4;
  localparam logic [2:0] S_GRANT  = 3'd5;
  localparam logic [2:0] S_NEXT   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [crg_pkg::CAP_W-1:0] cap_reg [crg_pkg::NUM_REGS];

  logic [2:0]  state, state_next;
  logic [IW-1:0] cur_k, cur_k_next;
  logic [1:0]  op_r;
  logic [7:0]  client_r;
  logic [31:0] req_r;
  logic        found, found_next;
  logic        shut_down, shut_next;
  logic [crg_pkg::RES_W-1:0] nres;
  logic        pend_valid;
  crg_pkg::entry_t pend_entry;
  logic        pend_grant;

  logic            emit, emit_grant, flush, accept;
  crg_pkg::entry_t emit_entry, in_entry, h_din;
  logic [IW-1:0]   kidx;

  crg_pkg::list_cmd_t hcmd [NUM_KINDS];
  crg_pkg::list_cmd_t wcmd [NUM_KINDS];
  logic [HCW-1:0]     h_count [NUM_KINDS];
  logic [WCW-1:0]     w_count [NUM_KINDS];
  logic               h_any [NUM_KINDS];
  logic               w_any [NUM_KINDS];
  logic               h_hit [NUM_KINDS];
  crg_pkg::entry_t    w_head [NUM_KINDS];

  logic [CW-1:0]   cap_cur, cap_acq;
  logic [HCW-1:0]  hc_cur, hc_acq;
  logic [WCW-1:0]  wc_cur, wc_acq;
  logic            h_any_cur, w_any_cur, h_hit_cur;
  crg_pkg::entry_t w_head_cur;
  logic [crg_pkg::CAP_W-1:0] raw_cur, raw_acq;

  assign accept        = start && !busy;
  assign busy          = (state != S_IDLE);
  assign kidx          = IW'(resource_kind);
  assign in_entry      = '{client: client_tag, request: request_tag};
  assign h_din         = (state == S_IDLE) ? in_entry : w_head_cur;
  assign pready        = 1'b1;
  assign prdata        = {28'd0, cap_reg[paddr[3:2]]};

  // Capacity registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < crg_pkg::NUM_REGS; j++) begin
        cap_reg[j] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      cap_reg[paddr[3:2]] <= pwdata[3:0];
    end
  end

  // Per-kind holder and waiter rows.
  for (genvar k = 0; k < NUM_KINDS; k++) begin : g_kind
    crg_list #(.DEPTH(MAX_HOLDERS)) u_hold (
      .clk        (clk),
      .rst        (rst),
      .cmd        (hcmd[k]),
      .key_client (client_r),
      .key_request(req_r),
      .din        (h_din),
      .head       (),
      .count      (h_count[k]),
      .any_mark   (h_any[k]),
      .hit        (h_hit[k])
    );
    crg_list #(.DEPTH(WAIT_DEPTH)) u_wait (
      .clk        (clk),
      .rst        (rst),
      .cmd        (wcmd[k]),
      .key_client (client_r),
      .key_request(req_r),
      .din        (in_entry),
      .head       (w_head[k]),
      .count      (w_count[k]),
      .any_mark   (w_any[k]),
      .hit        ()
    );
  end

  // Select the state of the kind being worked on and of the addressed kind.
  always_comb begin
    raw_cur    = '0;
    raw_acq    = '0;
    hc_cur     = '0;
    hc_acq     = '0;
    wc_cur     = '0;
    wc_acq     = '0;
    h_any_cur  = 1'b0;
    w_any_cur  = 1'b0;
    h_hit_cur  = 1'b0;
    w_head_cur = '0;
    for (int j = 0; j < crg_pkg::NUM_REGS; j++) begin
      if (j < NUM_KINDS) begin
        if (cur_k == IW'(j)) raw_cur = cap_reg[j];
        if (kidx == IW'(j))  raw_acq = cap_reg[j];
      end
    end
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (cur_k == IW'(k)) begin
        hc_cur     = h_count[k];
        wc_cur     = w_count[k];
        h_any_cur  = h_any[k];
        w_any_cur  = w_any[k];
        h_hit_cur  = h_hit[k];
        w_head_cur = w_head[k];
      end
      if (kidx == IW'(k)) begin
        hc_acq = h_count[k];
        wc_acq = w_count[k];
      end
    end
    cap_cur = (CW'(raw_cur) > CW'(MAX_HOLDERS)) ? CW'(MAX_HOLDERS) : CW'(raw_cur);
    cap_acq = (CW'(raw_acq) > CW'(MAX_HOLDERS)) ? CW'(MAX_HOLDERS) : CW'(raw_acq);
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    cur_k_next = cur_k;
    found_next = found;
    shut_next  = shut_down;
    emit       = 1'b0;
    emit_grant = 1'b0;
    emit_entry = in_entry;
    flush      = 1'b0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      hcmd[k] = '0;
      wcmd[k] = '0;
    end
    case (state)
      S_IDLE: begin
        if (accept && !shut_down) begin
          case (operation)
            crg_pkg::OP_ACQUIRE: begin
              state_next = S_FINISH;
              if (cap_acq == '0) begin
                emit = 1'b1;
              end else if (CW'(hc_acq) < cap_acq) begin
                emit       = 1'b1;
                emit_grant = 1'b1;
                for (int k = 0; k < NUM_KINDS; k++) begin
                  if (kidx == IW'(k)) hcmd[k].append = 1'b1;
                end
              end else if (!will_wait || (wc_acq == WCW'(WAIT_DEPTH))) begin
                emit = 1'b1;
              end else begin
                for (int k = 0; k < NUM_KINDS; k++) begin
                  if (kidx == IW'(k)) wcmd[k].append = 1'b1;
                end
              end
            end
            crg_pkg::OP_RELEASE_ONE: begin
              cur_k_next = kidx;
              state_next = S_CHECK;
            end
            crg_pkg::OP_RELEASE_CLIENT: begin
              cur_k_next = '0;
              state_next = S_CHECK;
            end
            default: begin
              shut_next = 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        state_next = (cap_cur == '0) ? S_NEXT : S_MARK;
      end
      S_MARK: begin
        // Mark the first matching holder, or every entry of the client.
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (cur_k == IW'(k)) begin
            hcmd[k].mark_one = (op_r == crg_pkg::OP_RELEASE_ONE);
            hcmd[k].mark_all = (op_r == crg_pkg::OP_RELEASE_CLIENT);
            wcmd[k].mark_all = (op_r == crg_pkg::OP_RELEASE_CLIENT);
          end
        end
        found_next = h_hit_cur;
        state_next = (op_r == crg_pkg::OP_RELEASE_ONE) ? S_MARKW : S_REMOVE;
      end
      S_MARKW: begin
        // Waiters are searched only when no holder matched.
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (cur_k == IW'(k)) wcmd[k].mark_one = !found;
        end
        state_next = S_REMOVE;
      end
      S_REMOVE: begin
        if (h_any_cur || w_any_cur) begin
          for (int k = 0; k < NUM_KINDS; k++) begin
            if (cur_k == IW'(k)) begin
              hcmd[k].remove = 1'b1;
              wcmd[k].remove = 1'b1;
            end
          end
        end else begin
          state_next = S_GRANT;
        end
      end
      S_GRANT: begin
        // Move the oldest waiter into the holders, one per cycle.
        if ((CW'(hc_cur) < cap_cur) && (wc_cur != '0) &&
            (nres < crg_pkg::RES_W'(crg_pkg::MAX_RESULTS))) begin
          emit       = 1'b1;
          emit_grant = 1'b1;
          emit_entry = w_head_cur;
          for (int k = 0; k < NUM_KINDS; k++) begin
            if (cur_k == IW'(k)) begin
              hcmd[k].append = 1'b1;
              wcmd[k].pop    = 1'b1;
            end
          end
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if ((op_r == crg_pkg::OP_RELEASE_CLIENT) && (cur_k != IW'(NUM_KINDS - 1))) begin
          cur_k_next = cur_k + IW'(1);
          state_next = S_CHECK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        flush      = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      shut_down <= 1'b0;
    end else begin
      state     <= state_next;
      shut_down <= shut_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_k <= cur_k_next;
    found <= found_next;
    if (accept) begin
      op_r     <= operation;
      client_r <= client_tag;
      req_r    <= request_tag;
    end
  end

  // One result is held back so the final one can carry the last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      nres       <= '0;
    end else begin
      strobe <= (emit || flush) && pend_valid;
      if ((emit || flush) && pend_valid) begin
        reply_client  <= pend_entry.client;
        reply_request <= pend_entry.request;
        granted       <= pend_grant;
        last          <= !emit;
      end
      if (emit) begin
        pend_valid <= 1'b1;
        pend_entry <= emit_entry;
        pend_grant <= emit_grant;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        nres <= emit ? crg_pkg::RES_W'(1) : '0;
      end else if (emit) begin
        nres <= nres + crg_pkg::RES_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/crg_checker.sv =====
`include "assert_macros.svh"

module crg_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input logic granted,
  input logic last,
  input logic pready
);

  // The final result of an item is never directly followed by another.
  `CRG_ASSERT_NXT(a_last_gap, strobe && last, !strobe)
  // A refusal only ever answers an acquire, so it is always the final result.
  `CRG_ASSERT_IMP(a_refuse_last, strobe && !granted, last)
  // Leaving reset, the block is idle and shows no result.
  `CRG_ASSERT_IMP(a_reset_idle, $past(rst), !strobe && !busy)
  // The configuration port never inserts wait states.
  `CRG_ASSERT_ALW(a_pready, pready)

endmodule

bind counted_resource_grant_with_wait_queue_top crg_checker u_crg_checker (.*);

// ===== sim/tb.sv =====
module tb;

  localparam int KINDS = 4;
  localparam int HOLD_MAX = 8;
  localparam int QDEPTH = 16;

  typedef struct packed {
    logic [7:0]  client;
    logic [31:0] request;
    logic        granted;
    logic        last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = crg_pkg::OP_ACQUIRE;
  logic [7:0]  client_tag = '0;
  logic [31:0] request_tag = '0;
  logic [1:0]  resource_kind = '0;
  logic        will_wait = 1'b0;
  logic        strobe;
  logic [7:0]  reply_client;
  logic [31:0] reply_request;
  logic        granted;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  counted_resource_grant_with_wait_queue_top u_dut (.*);

  always #2 clk = ~clk;

  // Shadow state of the grant pools.
  logic [3:0]      cap_shadow [KINDS];
  crg_pkg::entry_t holders [KINDS][HOLD_MAX];
  int              holder_n [KINDS];
  crg_pkg::entry_t waiters [KINDS][QDEPTH];
  int              waiter_n [KINDS];
  bit              is_shut;

  reply_t replies_due [$];
  int     errors = 0;
  int     replies_seen = 0;
  int     grants_seen = 0;
  int     queued_seen = 0;
  bit     quiet_sender = 1'b0;

  function automatic int pool_size(int k);
    return (cap_shadow[k] > HOLD_MAX) ? HOLD_MAX : int'(cap_shadow[k]);
  endfunction

  function automatic void push_reply(logic [7:0] c, logic [31:0] r, logic g);
    reply_t e;
    e.client = c;
    e.request = r;
    e.granted = g;
    e.last = 1'b0;
    replies_due.insert(replies_due.size(), e);
  endfunction

  // Grant the oldest waiters while their pool has room.
  function automatic void promote_waiters(int k, ref int n);
    while (holder_n[k] < pool_size(k) && waiter_n[k] > 0 && n < crg_pkg::MAX_RESULTS) begin
      push_reply(waiters[k][0].client, waiters[k][0].request, 1'b1);
      n++;
      holders[k][holder_n[k]] = waiters[k][0];
      holder_n[k]++;
      for (int i = 0; i + 1 < waiter_n[k]; i++) waiters[k][i] = waiters[k][i + 1];
      waiter_n[k]--;
    end
  endfunction

  // Work out the replies one accepted item causes.
  function automatic void predict_grants(logic [1:0] op, logic [7:0] c, logic [31:0] r,
                                         logic [1:0] k, logic w);
    int n;
    int pos;
    int wr;
    bit found;
    n = 0;
    if (is_shut) return;
    case (op)
      crg_pkg::OP_ACQUIRE: begin
        if (pool_size(k) == 0) begin
          push_reply(c, r, 1'b0);
          n++;
        end else if (holder_n[k] < pool_size(k)) begin
          holders[k][holder_n[k]] = {c, r};
          holder_n[k]++;
          push_reply(c, r, 1'b1);
          n++;
        end else if (!w || waiter_n[k] >= QDEPTH) begin
          push_reply(c, r, 1'b0);
          n++;
        end else begin
          waiters[k][waiter_n[k]] = {c, r};
          waiter_n[k]++;
          queued_seen++;
        end
      end
      crg_pkg::OP_RELEASE_ONE: begin
        if (pool_size(k) != 0) begin
          found = 1'b0;
          pos = -1;
          for (int i = 0; i < holder_n[k]; i++)
            if (pos < 0 && holders[k][i] == {c, r}) pos = i;
          if (pos >= 0) begin
            for (int i = pos; i + 1 < holder_n[k]; i++) holders[k][i] = holders[k][i + 1];
            holder_n[k]--;
            found = 1'b1;
          end
          pos = -1;
          if (!found)
            for (int i = 0; i < waiter_n[k]; i++)
              if (pos < 0 && waiters[k][i] == {c, r}) pos = i;
          if (pos >= 0) begin
            for (int i = pos; i + 1 < waiter_n[k]; i++) waiters[k][i] = waiters[k][i + 1];
            waiter_n[k]--;
          end
          promote_waiters(k, n);
        end
      end
      crg_pkg::OP_RELEASE_CLIENT: begin
        for (int kk = 0; kk < KINDS; kk++) begin
          if (pool_size(kk) != 0) begin
            wr = 0;
            for (int i = 0; i < holder_n[kk]; i++)
              if (holders[kk][i].client != c) begin
                holders[kk][wr] = holders[kk][i];
                wr++;
              end
            holder_n[kk] = wr;
            wr = 0;
            for (int i = 0; i < waiter_n[kk]; i++)
              if (waiters[kk][i].client != c) begin
                waiters[kk][wr] = waiters[kk][i];
                wr++;
              end
            waiter_n[kk] = wr;
            promote_waiters(kk, n);
          end
        end
      end
      default: is_shut = 1'b1;
    endcase
    if (n > 0) replies_due[$].last = 1'b1;
  endfunction

  // Compare each reply transfer against the oldest expectation.
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && strobe) begin
      replies_seen++;
      if (granted) grants_seen++;
      if (replies_due.size() == 0) begin
        $error("unexpected reply client=%0h request=%0h", reply_client, reply_request);
        errors++;
      end else begin
        exp_r = replies_due[0];
        replies_due.delete(0);
        if (reply_client !== exp_r.client) begin
          $error("reply_client expected %0h actual %0h", exp_r.client, reply_client);
          errors++;
        end
        if (reply_request !== exp_r.request) begin
          $error("reply_request expected %0h actual %0h", exp_r.request, reply_request);
          errors++;
        end
        if (granted !== exp_r.granted) begin
          $error("granted expected %0b actual %0b", exp_r.granted, granted);
          errors++;
        end
        if (last !== exp_r.last) begin
          $error("last expected %0b actual %0b", exp_r.last, last);
          errors++;
        end
      end
    end
  end

  // Send one item; the transfer happens on the edge where start meets a low busy.
  task automatic send_item(logic [1:0] op, logic [7:0] c, logic [31:0] r,
                           logic [1:0] k, logic w);
    while (!quiet_sender && $urandom_range(99) < 28) @(posedge clk);
    operation <= op;
    client_tag <= c;
    request_tag <= r;
    resource_kind <= k;
    will_wait <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_grants(op, c, r, k, w);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block drain, then allow for work that ends without a reply.
  task automatic drain();
    int guard;
    guard = 0;
    while (replies_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_capacity(int idx, logic [3:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx * 4);
    pwdata <= {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_shadow[idx] = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacities(logic [3:0] c0, logic [3:0] c1, logic [3:0] c2,
                                logic [3:0] c3);
    drain();
    write_capacity(0, c0);
    write_capacity(1, c1);
    write_capacity(2, c2);
    write_capacity(3, c3);
  endtask

  // Directed: field extremes, waiting, full queue, releases, unknown release.
  task automatic test_directed();
    set_capacities(4'd1, 4'd2, 4'd0, 4'd15);
    send_item(crg_pkg::OP_ACQUIRE, 8'h00, 32'h0, 2'd0, 1'b0);
    send_item(crg_pkg::OP_ACQUIRE, 8'hff, 32'hffffffff, 2'd0, 1'b0);
    send_item(crg_pkg::OP_ACQUIRE, 8'h11, 32'h1, 2'd0, 1'b1);
    send_item(crg_pkg::OP_ACQUIRE, 8'h12, 32'h2, 2'd0, 1'b1);
    send_item(crg_pkg::OP_ACQUIRE, 8'h13, 32'h3, 2'd2, 1'b1);
    send_item(crg_pkg::OP_RELEASE_ONE, 8'h00, 32'h0, 2'd0, 1'b0);
    send_item(crg_pkg::OP_RELEASE_ONE, 8'h12, 32'h2, 2'd0, 1'b0);
    send_item(crg_pkg::OP_RELEASE_ONE, 8'h77, 32'h77, 2'd0, 1'b0);
    send_item(crg_pkg::OP_RELEASE_ONE, 8'h77, 32'h77, 2'd2, 1'b0);
    for (int i = 0; i < 10; i++)
      send_item(crg_pkg::OP_ACQUIRE, 8'(i), 32'(i), 2'd3, 1'b1);
    send_item(crg_pkg::OP_RELEASE_CLIENT, 8'h11, 32'h0, 2'd0, 1'b0);
    send_item(crg_pkg::OP_RELEASE_CLIENT, 8'h03, 32'h0, 2'd1, 1'b0);
    set_capacities(4'd1, 4'd1, 4'd1, 4'd1);
    for (int i = 0; i < 18; i++)
      send_item(crg_pkg::OP_ACQUIRE, 8'h40, 32'h100 + i, 2'd1, 1'b1);
    // Lowering a capacity leaves current holders in place.
    set_capacities(4'd1, 4'd1, 4'd1, 4'd0);
    set_capacities(4'd1, 4'd1, 4'd1, 4'd8);
    send_item(crg_pkg::OP_RELEASE_CLIENT, 8'h40, 32'h0, 2'd0, 1'b0);
  endtask

  // Random traffic over a small set of clients and requests so hits are common.
  task automatic test_random(int count);
    logic [1:0] op;
    logic [7:0] c;
    logic [31:0] r;
    int roll;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0)
        set_capacities(4'($urandom_range(0, 15)), 4'($urandom_range(1, 8)),
                       4'($urandom_range(1, 3)), 4'($urandom_range(1, 2)));
      quiet_sender = (i >= 120 && i < 170);
      roll = $urandom_range(99);
      op = (roll < 55) ? crg_pkg::OP_ACQUIRE :
           (roll < 90) ? crg_pkg::OP_RELEASE_ONE : crg_pkg::OP_RELEASE_CLIENT;
      c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      r = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 7));
      send_item(op, c, r, 2'($urandom), 1'($urandom_range(0, 3) != 0));
    end
    quiet_sender = 1'b0;
  endtask

  // Shutdown: every later item is ignored, register writes still land.
  task automatic test_shutdown();
    send_item(crg_pkg::OP_SHUTDOWN, 8'h5a, 32'h5a5a5a5a, 2'd1, 1'b1);
    set_capacities(4'd8, 4'd8, 4'd8, 4'd8);
    for (int i = 0; i < 6; i++)
      send_item(2'($urandom), 8'($urandom), $urandom, 2'($urandom), 1'($urandom));
    drain();
  endtask

  initial begin
    for (int k = 0; k < KINDS; k++) begin
      cap_shadow[k] = '0;
      holder_n[k] = 0;
      waiter_n[k] = 0;
    end
    is_shut = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(270);
    test_shutdown();
    $display("Ran %0d replies (%0d grants, %0d queued acquires) over several capacity sets.",
             replies_seen, grants_seen, queued_seen);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("** counted_resource_grant_with_wait_queue_top: PASSED **");
    end else begin
      $display("** counted_resource_grant_with_wait_queue_top: FAILED **");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #4000000;
    $display("** counted_resource_grant_with_wait_queue_top: FAILED **");
    $finish;
  end

endmodule
